// ===== rtl/decimal_bignum_scale_by_digit_unit_defines.svh =====
// Assertion macros shared by the decimal scaler RTL.
// Included by the top level; depends on nothing else.
`ifndef DECIMAL_BIGNUM_SCALE_BY_DIGIT_UNIT_DEFINES_SVH
`define DECIMAL_BIGNUM_SCALE_BY_DIGIT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DBSD_CHECK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DBSD_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dbsd_pkg.sv =====
// Shared types and constants for the decimal scaler.
// No dependencies; imported by the digit ALU, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package dbsd_pkg;

    localparam int DIGIT_W            = 4;
    localparam int MAX_NUM_DIGITS_DEF = 32;
    localparam int RADIX              = 10;
    localparam int DIGIT_MAX          = 9;

    // Reciprocal of ten: (p * 205) >> 11 equals p / 10 for every p below 1029.
    localparam int RECIP10       = 205;
    localparam int RECIP10_SHIFT = 11;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_MUL    = 2'd2,
        CMD_DIV    = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_EMIT = 5'b01000,
        S_ERR  = 5'b10000
    } state_t;

    // Result of one digit step: the new digit and the carry or remainder.
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [DIGIT_W-1:0] carry;
    } alu_res_t;

endpackage

`default_nettype wire

// ===== rtl/dbsd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Write-first on an address collision; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dbsd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Storage write and registered read; a same-address write is passed through.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rdata <= wdata;
        end
        else
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dbsd_digit_alu.sv =====
// One decimal digit step: multiply with carry, or divide with remainder.
// Depends on dbsd_pkg for the digit width, radix and result struct.
`timescale 1ns / 1ps
`default_nettype none

module dbsd_digit_alu import dbsd_pkg::*; (
    input  wire logic               div_mode,
    input  wire logic [DIGIT_W-1:0] digit,
    input  wire logic [DIGIT_W-1:0] operand,
    input  wire logic [DIGIT_W-1:0] acc,
    output alu_res_t                res
);

    logic [6:0]         prod;
    logic [14:0]        recip;
    logic [DIGIT_W-1:0] mul_carry;
    logic [6:0]         mul_rem;
    logic [6:0]         cur;
    logic [DIGIT_W-1:0] div_q;
    logic [6:0]         div_rem;

    // Multiply step: product plus incoming carry, split into digit and carry.
    always_comb
    begin
        prod      = 7'(digit) * 7'(operand) + 7'(acc);
        recip     = 15'(prod) * 15'(RECIP10);
        mul_carry = 4'(recip >> RECIP10_SHIFT);
        mul_rem   = prod - 7'(mul_carry) * 7'(RADIX);
    end

    // Divide step: the quotient digit is the largest k (at most 9) whose multiple of the divisor fits.
    always_comb
    begin
        cur   = 7'(acc) * 7'(RADIX) + 7'(digit);
        div_q = '0;
        for (int k = 1; k <= DIGIT_MAX; k++)
        begin
            if (cur >= 7'(operand) * 7'(k))
            begin
                div_q = 4'(k);
            end
        end
        div_rem = cur - 7'(operand) * 7'(div_q);
    end

    assign res.digit = div_mode ? div_q : mul_rem[DIGIT_W-1:0];
    assign res.carry = div_mode ? div_rem[DIGIT_W-1:0] : mul_carry;

endmodule

`default_nettype wire

// ===== rtl/decimal_bignum_scale_by_digit_unit.sv =====
// Decimal number of up to MAX_NUM_DIGITS digits, scaled in place by a factor of 0 to 9 or
// a divisor of 1 to 9. Clear and append are done without leaving the idle state, except an
// append to a full number. A multiply walks the stored digits from the least significant
// end, one per cycle, into a scratch RAM, then streams the result out most significant
// first while copying it back, one result digit per free output slot. A divide walks the
// digits from the most significant end in place and then streams the quotient digits.
// The pace is set by the single digit ALU and the one-digit-per-cycle RAM ports.
// Overflow and a full append give one error transaction and leave the number unchanged.
// Digits are stored in RAM with no reset; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

`include "decimal_bignum_scale_by_digit_unit_defines.svh"

module decimal_bignum_scale_by_digit_unit import dbsd_pkg::*; #(
    parameter int MAX_NUM_DIGITS = MAX_NUM_DIGITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         command,
    input  wire logic [DIGIT_W-1:0] digit_in,
    input  wire logic [DIGIT_W-1:0] operand,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [DIGIT_W-1:0]      digit_out,
    output logic                    last_digit,
    output logic                    error
);

    localparam int CW = $clog2(MAX_NUM_DIGITS + 1);
    localparam int AW = $clog2(MAX_NUM_DIGITS);
    localparam logic [CW-1:0] CountMax = CW'(MAX_NUM_DIGITS);

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [DIGIT_W-1:0] op_reg, op_next;
    logic [DIGIT_W-1:0] acc_reg, acc_next;
    logic [DIGIT_W-1:0] lead_reg, lead_next;
    logic               lead_pend_reg, lead_pend_next;
    logic               from_scr_reg, from_scr_next;

    logic               out_valid_reg;
    logic [DIGIT_W-1:0] digit_out_reg;
    logic               last_reg;
    logic               error_reg;

    logic               accept;
    logic               out_free;
    logic               load_out;
    logic [DIGIT_W-1:0] ld_digit;
    logic               ld_last;
    logic               ld_err;
    logic [DIGIT_W-1:0] din_sat;
    logic [DIGIT_W-1:0] op_sat;
    logic [CW-1:0]      n_after;
    logic               div_wr;

    logic               st_we;
    logic [AW-1:0]      st_waddr;
    logic [DIGIT_W-1:0] st_wdata;
    logic [DIGIT_W-1:0] st_q;
    logic               sc_we;
    logic [AW-1:0]      sc_waddr;
    logic [DIGIT_W-1:0] sc_wdata;
    logic [DIGIT_W-1:0] sc_q;
    logic [AW-1:0]      rd_addr;

    alu_res_t           alu_res;

    // Digit store and multiply scratch; read data always matches idx_reg.
    dbsd_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_NUM_DIGITS)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (rd_addr),
        .rdata (st_q)
    );

    dbsd_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_NUM_DIGITS)
    ) u_scratch (
        .clk   (clk),
        .we    (sc_we),
        .waddr (sc_waddr),
        .wdata (sc_wdata),
        .raddr (rd_addr),
        .rdata (sc_q)
    );

    // Shared digit ALU for both the multiply and the divide walk.
    dbsd_digit_alu u_alu (
        .div_mode (state_reg == S_DIV),
        .digit    (st_q),
        .operand  (op_reg),
        .acc      (acc_reg),
        .res      (alu_res)
    );

    // Handshake and input clean-up.
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign din_sat  = (digit_in > 4'(DIGIT_MAX)) ? 4'(DIGIT_MAX) : digit_in;
    assign op_sat   = (operand > 4'(DIGIT_MAX)) ? 4'(DIGIT_MAX) : operand;
    assign div_wr   = (alu_res.digit != '0) || (pos_reg != '0);
    assign n_after  = div_wr ? CW'(pos_reg + CW'(1)) : pos_reg;
    assign rd_addr  = idx_next[AW-1:0];

    // Sequencer: command decode, digit walks and result streaming.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        op_next        = op_reg;
        acc_next       = acc_reg;
        lead_next      = lead_reg;
        lead_pend_next = lead_pend_reg;
        from_scr_next  = from_scr_reg;
        st_we          = 1'b0;
        st_waddr       = '0;
        st_wdata       = '0;
        sc_we          = 1'b0;
        sc_waddr       = idx_reg[AW-1:0];
        sc_wdata       = alu_res.digit;
        load_out       = 1'b0;
        ld_digit       = '0;
        ld_last        = 1'b0;
        ld_err         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_t'(command))
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg >= CountMax)
                            begin
                                state_next = S_ERR;
                            end
                            else
                            begin
                                st_we      = 1'b1;
                                st_waddr   = count_reg[AW-1:0];
                                st_wdata   = din_sat;
                                count_next = CW'(count_reg + CW'(1));
                            end
                        end
                        CMD_MUL, CMD_DIV:
                        begin
                            acc_next       = '0;
                            lead_pend_next = 1'b0;
                            from_scr_next  = 1'b0;
                            pos_next       = '0;
                            if ((cmd_t'(command) == CMD_DIV) && (op_sat == '0))
                            begin
                                op_next = 4'd1;
                            end
                            else
                            begin
                                op_next = op_sat;
                            end
                            if (count_reg == '0)
                            begin
                                // An empty number becomes a single zero digit.
                                st_we      = 1'b1;
                                st_waddr   = '0;
                                st_wdata   = '0;
                                count_next = CW'(1);
                                idx_next   = '0;
                                state_next = S_EMIT;
                            end
                            else if (cmd_t'(command) == CMD_MUL)
                            begin
                                idx_next   = CW'(count_reg - CW'(1));
                                state_next = S_MUL;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_DIV;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_MUL:
            begin
                // Least significant digit first; the product goes to scratch.
                sc_we    = 1'b1;
                acc_next = alu_res.carry;
                if (idx_reg == '0)
                begin
                    if ((alu_res.carry != '0) && (count_reg >= CountMax))
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        from_scr_next  = 1'b1;
                        lead_next      = alu_res.carry;
                        lead_pend_next = (alu_res.carry != '0);
                        if (alu_res.carry != '0)
                        begin
                            count_next = CW'(count_reg + CW'(1));
                        end
                        idx_next   = '0;
                        pos_next   = '0;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    idx_next = CW'(idx_reg - CW'(1));
                end
            end

            S_DIV:
            begin
                // Most significant digit first; leading zeros are not stored.
                acc_next = alu_res.carry;
                if (div_wr)
                begin
                    st_we    = 1'b1;
                    st_waddr = pos_reg[AW-1:0];
                    st_wdata = alu_res.digit;
                end
                if (idx_reg == CW'(count_reg - CW'(1)))
                begin
                    idx_next      = '0;
                    pos_next      = '0;
                    from_scr_next = 1'b0;
                    state_next    = S_EMIT;
                    if (n_after == '0)
                    begin
                        st_we      = 1'b1;
                        st_waddr   = '0;
                        st_wdata   = '0;
                        count_next = CW'(1);
                    end
                    else
                    begin
                        count_next = n_after;
                    end
                end
                else
                begin
                    idx_next = CW'(idx_reg + CW'(1));
                    pos_next = n_after;
                end
            end

            S_EMIT:
            begin
                // One result digit per free output slot; a product is copied back.
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (lead_pend_reg)
                    begin
                        ld_digit = lead_reg;
                    end
                    else if (from_scr_reg)
                    begin
                        ld_digit = sc_q;
                    end
                    else
                    begin
                        ld_digit = st_q;
                    end
                    ld_last = (pos_reg == CW'(count_reg - CW'(1)));
                    if (from_scr_reg)
                    begin
                        st_we    = 1'b1;
                        st_waddr = pos_reg[AW-1:0];
                        st_wdata = ld_digit;
                    end
                    pos_next = CW'(pos_reg + CW'(1));
                    if (lead_pend_reg)
                    begin
                        lead_pend_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = CW'(idx_reg + CW'(1));
                    end
                    if (ld_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_ERR:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    ld_digit   = '0;
                    ld_last    = 1'b1;
                    ld_err     = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            lead_pend_reg <= 1'b0;
            from_scr_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            lead_pend_reg <= lead_pend_next;
            from_scr_reg  <= from_scr_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers, including the output transaction payload.
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        acc_reg  <= acc_next;
        lead_reg <= lead_next;
        if (load_out)
        begin
            digit_out_reg <= ld_digit;
            last_reg      <= ld_last;
            error_reg     <= ld_err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_out  = digit_out_reg;
    assign last_digit = last_reg;
    assign error      = error_reg;

    // Design checks.
    `DBSD_CHECK(a_count_range, clk, rst_n, 1'b1, count_reg <= CountMax, "digit count past capacity")
    `DBSD_CHECK(a_emit_nonempty, clk, rst_n, state_reg == S_EMIT, count_reg != '0, "streaming an empty number")
    `DBSD_CHECK(a_div_rem, clk, rst_n, state_reg == S_DIV, acc_reg < op_reg, "remainder not below divisor")
    `DBSD_CHECK(a_err_last, clk, rst_n, out_valid && error, last_digit, "error transaction not marked last")
    `DBSD_CHECK_NEXT(a_err_load, clk, rst_n, (state_reg == S_ERR) && out_free, out_valid && error, "error transaction not issued")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the decimal scaler: clear, append, multiply and divide.
// Depends on dbsd_pkg and decimal_bignum_scale_by_digit_unit, which brings in the RAM, ALU and defines.
`timescale 1ns / 1ps

module tb_top import dbsd_pkg::*;;

    localparam int DIGITS           = MAX_NUM_DIGITS_DEF;
    localparam int ITEM_TARGET      = 160;
    localparam int QUIET_ITEMS      = 20;
    localparam int HOLD_AFTER_ITEMS = 60;
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 2 * DIGITS + 16;
    localparam int CYCLE_LIMIT      = 600000;

    // One expected output transaction.
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last;
        logic               err;
    } digit_result_t;

    // Keeps its own copy of the stored number and the digits it must emit next.
    class scaler_scoreboard;
        logic [DIGIT_W-1:0] stored_digits [DIGITS];
        int unsigned        stored_len;
        digit_result_t      expected_digits [$];
        int                 mismatches;

        function new();
            stored_len = 0;
            mismatches = 0;
        endfunction

        function int pending_count();
            return expected_digits.size();
        endfunction

        function void push_result(logic [DIGIT_W-1:0] d, logic last, logic err);
            digit_result_t r;
            r.digit = d;
            r.last  = last;
            r.err   = err;
            expected_digits.push_back(r);
        endfunction

        function void push_number();
            for (int i = 0; i < int'(stored_len); i++)
                push_result(stored_digits[i], (i + 1 == int'(stored_len)), 1'b0);
        endfunction

        function void set_zero();
            stored_digits[0] = '0;
            stored_len       = 1;
            push_number();
        endfunction

        // Long multiplication from the least significant digit upward.
        function void multiply_by(int unsigned factor);
            logic [DIGIT_W-1:0] product [DIGITS];
            int unsigned        carry;
            int unsigned        p;
            carry = 0;
            if (stored_len == 0)
            begin
                set_zero();
                return;
            end
            for (int i = int'(stored_len) - 1; i >= 0; i--)
            begin
                p          = stored_digits[i] * factor + carry;
                product[i] = DIGIT_W'(p % RADIX);
                carry      = p / RADIX;
            end
            if (carry != 0)
            begin
                // A carry out of a full number is a capacity error.
                if (stored_len >= DIGITS)
                begin
                    push_result('0, 1'b1, 1'b1);
                    return;
                end
                for (int i = int'(stored_len); i >= 1; i--)
                    stored_digits[i] = product[i - 1];
                stored_digits[0] = DIGIT_W'(carry);
                stored_len++;
            end
            else
            begin
                for (int i = 0; i < int'(stored_len); i++)
                    stored_digits[i] = product[i];
            end
            push_number();
        endfunction

        // Long division from the most significant digit; leading zeros are dropped.
        function void divide_by(int unsigned divisor);
            int unsigned rem;
            int unsigned cur;
            int unsigned q;
            int unsigned kept;
            rem  = 0;
            kept = 0;
            for (int i = 0; i < int'(stored_len); i++)
            begin
                cur = rem * RADIX + stored_digits[i];
                q   = cur / divisor;
                rem = cur % divisor;
                if (q != 0 || kept != 0)
                begin
                    stored_digits[kept] = DIGIT_W'(q);
                    kept++;
                end
            end
            if (kept == 0)
            begin
                set_zero();
                return;
            end
            stored_len = kept;
            push_number();
        endfunction

        // Notes an accepted input transaction and queues the digits it causes.
        function void note_command(cmd_t cmd, logic [DIGIT_W-1:0] d, logic [DIGIT_W-1:0] op);
            int unsigned digit_val;
            int unsigned op_val;
            digit_val = (d > DIGIT_MAX) ? DIGIT_MAX : d;
            op_val    = (op > DIGIT_MAX) ? DIGIT_MAX : op;
            case (cmd)
                CMD_CLEAR: stored_len = 0;
                CMD_APPEND:
                begin
                    if (stored_len >= DIGITS)
                    begin
                        push_result('0, 1'b1, 1'b1);
                    end
                    else
                    begin
                        stored_digits[stored_len] = DIGIT_W'(digit_val);
                        stored_len++;
                    end
                end
                CMD_MUL: multiply_by(op_val);
                default: divide_by((op_val == 0) ? 1 : op_val);
            endcase
        endfunction

        // Checks one output transaction against the oldest expectation.
        function void check_digit(logic [DIGIT_W-1:0] d, logic last, logic err);
            digit_result_t want;
            if (expected_digits.size() == 0)
            begin
                $error("unexpected result: digit_out %0d last_digit %0d error %0d", d, last, err);
                mismatches++;
                return;
            end
            want = expected_digits.pop_front();
            if (want.digit !== d)
            begin
                $error("digit_out: expected %0d, actual %0d", want.digit, d);
                mismatches++;
            end
            if (want.last !== last)
            begin
                $error("last_digit: expected %0d, actual %0d", want.last, last);
                mismatches++;
            end
            if (want.err !== err)
            begin
                $error("error: expected %0d, actual %0d", want.err, err);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         command;
    logic [DIGIT_W-1:0] digit_in;
    logic [DIGIT_W-1:0] operand;
    logic               out_valid;
    logic               out_stall;
    logic [DIGIT_W-1:0] digit_out;
    logic               last_digit;
    logic               error;

    scaler_scoreboard sb = new();

    int  cycle_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  errors_seen = 0;
    int  gap_odds = 0;
    bit  quiet_tail = 1'b0;
    bit  hold_done = 1'b0;

    decimal_bignum_scale_by_digit_unit #(
        .MAX_NUM_DIGITS(DIGITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .digit_in  (digit_in),
        .operand   (operand),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .digit_out (digit_out),
        .last_digit(last_digit),
        .error     (error)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle counter and watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d digits outstanding.",
                     cycle_count, sb.pending_count());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Output monitor: a transaction completes when valid is high and stall is low.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (error)
                errors_seen++;
            sb.check_digit(digit_out, last_digit, error);
        end
    end

    // Receiver back-pressure: random stall bursts, one long hold-off, none at the end.
    initial
    begin
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!hold_done && items_sent >= HOLD_AFTER_ITEMS)
            begin
                // Hold long enough for the block to fill and stall its input.
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (quiet_tail)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 19)) @(posedge clk);
                end
                out_stall <= 1'b0;
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(60, 150)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // Offers one input transaction, with an optional idle gap first, and waits for it to go in.
    task automatic send_item(cmd_t cmd, logic [DIGIT_W-1:0] d, logic [DIGIT_W-1:0] op);
        if (!quiet_tail && gap_odds != 0 && $urandom_range(1, 4) <= gap_odds)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        digit_in <= d;
        operand  <= op;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_command(cmd, d, op);
        items_sent++;
        if (items_sent >= ITEM_TARGET - QUIET_ITEMS)
            quiet_tail = 1'b1;
    endtask

    // Mostly legal digits, sometimes values above nine that must saturate.
    function automatic logic [DIGIT_W-1:0] pick_digit();
        if ($urandom_range(0, 7) == 0)
            return DIGIT_W'($urandom_range(10, 15));
        return DIGIT_W'($urandom_range(0, 9));
    endfunction

    // Mostly 1 to 9, sometimes zero or above nine.
    function automatic logic [DIGIT_W-1:0] pick_operand();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return DIGIT_W'($urandom_range(10, 15));
        return DIGIT_W'($urandom_range(1, 9));
    endfunction

    // One random sequence: usually build a number and scale it, sometimes noise.
    task automatic run_sequence(bit force_fill);
        int kind;
        int n_digits;
        gap_odds = $urandom_range(0, 2);
        kind     = force_fill ? 1 : $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 4))
                send_item(cmd_t'($urandom_range(0, 3)), DIGIT_W'($urandom), DIGIT_W'($urandom));
        end
        else
        begin
            if (force_fill || $urandom_range(0, 4) != 0)
                send_item(CMD_CLEAR, DIGIT_W'($urandom), DIGIT_W'($urandom));
            // Filling sequences append 29 to DIGITS + 2 digits and may run into the capacity limit.
            n_digits = (kind == 1) ? $urandom_range(29, DIGITS + 2) : $urandom_range(0, 8);
            repeat (n_digits)
                send_item(CMD_APPEND, pick_digit(), DIGIT_W'($urandom));
            if (kind == 1)
                send_item(CMD_MUL, DIGIT_W'($urandom), DIGIT_W'(DIGIT_MAX));
            repeat ($urandom_range(1, 4))
                send_item($urandom_range(0, 1) ? CMD_MUL : CMD_DIV, DIGIT_W'($urandom),
                          pick_operand());
        end
    endtask

    // Main stimulus.
    initial
    begin
        bit first;
        first = 1'b1;
        in_valid <= 1'b0;
        command  <= CMD_CLEAR;
        digit_in <= '0;
        operand  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty number, zero and oversized operands, saturated digits.
        gap_odds = 1;
        send_item(CMD_MUL, 4'd0, 4'd0);
        send_item(CMD_CLEAR, 4'd15, 4'd15);
        send_item(CMD_DIV, 4'd0, 4'd0);
        send_item(CMD_CLEAR, 4'd0, 4'd0);
        send_item(CMD_APPEND, 4'd15, 4'd0);
        send_item(CMD_APPEND, 4'd0, 4'd15);
        send_item(CMD_APPEND, 4'd9, 4'd0);
        send_item(CMD_MUL, 4'd0, 4'd15);
        send_item(CMD_MUL, 4'd15, 4'd0);
        send_item(CMD_DIV, 4'd0, 4'd7);
        send_item(CMD_CLEAR, 4'd0, 4'd0);
        send_item(CMD_APPEND, 4'd1, 4'd0);
        send_item(CMD_APPEND, 4'd2, 4'd0);
        send_item(CMD_APPEND, 4'd3, 4'd0);
        send_item(CMD_DIV, 4'd0, 4'd9);
        send_item(CMD_DIV, 4'd0, 4'd14);
        send_item(CMD_DIV, 4'd0, 4'd3);
        send_item(CMD_MUL, 4'd0, 4'd1);
        send_item(CMD_CLEAR, 4'd0, 4'd0);
        send_item(CMD_APPEND, 4'd0, 4'd0);
        send_item(CMD_APPEND, 4'd5, 4'd0);
        send_item(CMD_MUL, 4'd0, 4'd1);
        send_item(CMD_DIV, 4'd0, 4'd5);

        // Random sequences; the first one is a filling sequence, which may reach capacity.
        while (items_sent < ITEM_TARGET)
        begin
            run_sequence(first);
            first = 1'b0;
        end
        in_valid <= 1'b0;

        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands and checked %0d result digits in %0d cycles.",
                 items_sent, results_seen, cycle_count);
        $display("Capacity errors seen: %0d; long receiver hold-off done: %0d.",
                 errors_seen, hold_done);
        if (sb.mismatches == 0 && sb.pending_count() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
